>>> hdl/sdmn_pkg.sv
// shared types and constants for the signed division magic number block
`default_nettype none

package sdmn_pkg;

  localparam int unsigned RESULT_BITS = 32;
  localparam int unsigned SHIFT_BITS  = 5;

  typedef struct packed {
    logic valid;
    logic inv;
    logic neg;
    logic done;
  } sdmn_ctl_t;

endpackage

`default_nettype wire

>>> hdl/sdmn_rem_stage.sv
// one restoring remainder step of the divisor bias modulo |d|
`default_nettype none

module sdmn_rem_stage #(
  parameter int W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdmn_pkg::sdmn_ctl_t ctl_i,
  input  logic              din_bit_i,
  input  logic [W-1:0]      ad_i,
  input  logic [W-1:0]      rem_i,
  output sdmn_pkg::sdmn_ctl_t ctl_o,
  output logic [W-1:0]      ad_o,
  output logic [W-1:0]      rem_o
);
  import sdmn_pkg::*;

  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic [W-1:0] rem_d;
  sdmn_ctl_t    ctl_q;
  logic [W-1:0] ad_q;
  logic [W-1:0] rem_q;

  assign shifted = {rem_i, din_bit_i};
  assign diff    = shifted - {1'b0, ad_i};

  always_comb begin
    if (shifted >= {1'b0, ad_i}) begin
      rem_d = diff[W-1:0];
    end else begin
      rem_d = shifted[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q  <= ad_i;
    rem_q <= rem_d;
  end

  assign ctl_o = ctl_q;
  assign ad_o  = ad_q;
  assign rem_o = rem_q;

endmodule

`default_nettype wire

>>> hdl/sdmn_div_stage.sv
// one long-division step on both quotients, with the stopping test in loop stages
`default_nettype none

module sdmn_div_stage #(
  parameter int W  = 32,
  parameter int CW = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdmn_pkg::sdmn_ctl_t ctl_i,
  input  logic              din_bit_i,
  input  logic              test_i,
  input  logic [W-1:0]      ad_i,
  input  logic [W-1:0]      anc_i,
  input  logic [W-1:0]      q1_i,
  input  logic [W-1:0]      r1_i,
  input  logic [W-1:0]      q2_i,
  input  logic [W-1:0]      r2_i,
  input  logic [CW-1:0]     cnt_i,
  output sdmn_pkg::sdmn_ctl_t ctl_o,
  output logic [W-1:0]      ad_o,
  output logic [W-1:0]      anc_o,
  output logic [W-1:0]      q1_o,
  output logic [W-1:0]      r1_o,
  output logic [W-1:0]      q2_o,
  output logic [W-1:0]      r2_o,
  output logic [CW-1:0]     cnt_o
);
  import sdmn_pkg::*;

  logic [W:0]    s1, s2, d1, d2;
  logic          ge1, ge2;
  logic [W-1:0]  r1n, r2n, q1n, q2n, delta;
  logic          stop;
  sdmn_ctl_t     ctl_d, ctl_q;
  logic [W-1:0]  q1_d, r1_d, q2_d, r2_d;
  logic [CW-1:0] cnt_d;
  logic [W-1:0]  ad_q, anc_q, q1_q, r1_q, q2_q, r2_q;
  logic [CW-1:0] cnt_q;

  assign s1  = {r1_i, din_bit_i};
  assign s2  = {r2_i, din_bit_i};
  assign d1  = s1 - {1'b0, anc_i};
  assign d2  = s2 - {1'b0, ad_i};
  assign ge1 = s1 >= {1'b0, anc_i};
  assign ge2 = s2 >= {1'b0, ad_i};
  assign r1n = ge1 ? d1[W-1:0] : s1[W-1:0];
  assign r2n = ge2 ? d2[W-1:0] : s2[W-1:0];
  assign q1n = {q1_i[W-2:0], ge1};
  assign q2n = {q2_i[W-2:0], ge2};

  // keep refining while 2^p/anc <= |d| - (2^p mod |d|)
  assign delta = ad_i - r2n;
  assign stop  = !((q1n < delta) || ((q1n == delta) && (r1n == '0)));

  always_comb begin
    ctl_d = ctl_i;
    q1_d  = q1n;
    r1_d  = r1n;
    q2_d  = q2n;
    r2_d  = r2n;
    cnt_d = cnt_i;
    if (test_i && ctl_i.done) begin
      q1_d = q1_i;
      r1_d = r1_i;
      q2_d = q2_i;
      r2_d = r2_i;
    end else if (test_i) begin
      cnt_d      = cnt_i + CW'(1);
      ctl_d.done = stop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q  <= ad_i;
    anc_q <= anc_i;
    q1_q  <= q1_d;
    r1_q  <= r1_d;
    q2_q  <= q2_d;
    r2_q  <= r2_d;
    cnt_q <= cnt_d;
  end

  assign ctl_o = ctl_q;
  assign ad_o  = ad_q;
  assign anc_o = anc_q;
  assign q1_o  = q1_q;
  assign r1_o  = r1_q;
  assign q2_o  = q2_q;
  assign r2_o  = r2_q;
  assign cnt_o = cnt_q;

  // once a loop has stopped, later stages keep it stopped
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid && ctl_i.done |=> ctl_q.done && ctl_q.valid)
    else $error("stopped transaction resumed refinement");

endmodule

`default_nettype wire

>>> hdl/signed_div_magic_number.sv
// top level: pipelined magic multiplier and shift for signed division by a constant
//
// A transaction is taken at every clock edge where start is high; busy stays low,
// since the block is a full pipeline with one long-division step per stage. Each
// result appears on the result ports for one cycle with valid_o high, after passing
// through one decode stage, WORD_BITS remainder steps, one bias stage, WORD_BITS
// quotient steps, 2*WORD_BITS refinement steps and one output stage. The receiver
// cannot stall the results.
// Divisors -1, 0 and 1 give divisor_invalid_o high with zero multiplier and shift.
`default_nettype none

module signed_div_magic_number #(
  parameter int WORD_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [31:0]                    divisor_i,
  output logic                                  valid_o,
  output logic [sdmn_pkg::RESULT_BITS-1:0]      magic_multiplier_o,
  output logic [sdmn_pkg::SHIFT_BITS-1:0]       shift_amount_o,
  output logic                                  divisor_invalid_o
);
  import sdmn_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int CW  = $clog2(2 * W + 1);
  localparam int NL  = 3 * W;
  localparam int LAT = 4 * W + 3;

  // decode stage
  logic [W-1:0] w;
  logic         dec_inv, dec_neg;
  logic [W-1:0] dec_ad;

  assign w       = W'(divisor_i);
  assign dec_neg = w[W-1];
  assign dec_inv = (w == '0) || (w == W'(1)) || (w == '1);
  assign dec_ad  = dec_neg ? (~w + W'(1)) : w;

  sdmn_ctl_t    rem_ctl [0:W];
  logic [W-1:0] rem_ad  [0:W];
  logic [W-1:0] rem_r   [0:W];

  sdmn_ctl_t    dec_ctl_q;
  logic [W-1:0] dec_ad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_ctl_q <= '0;
    end else begin
      dec_ctl_q.valid <= start && !busy;
      dec_ctl_q.inv   <= dec_inv;
      dec_ctl_q.neg   <= dec_neg;
      dec_ctl_q.done  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_ad_q <= dec_ad;
  end

  assign rem_ctl[0] = dec_ctl_q;
  assign rem_ad[0]  = dec_ad_q;
  assign rem_r[0]   = '0;

  // bias t = 2^(W-1) + sign: top bit first, sign bit last
  for (genvar j = 0; j < W; j++) begin : g_rem
    logic din;
    if (j == 0) begin : g_first
      assign din = 1'b1;
    end else if (j == W - 1) begin : g_last
      assign din = rem_ctl[j].neg;
    end else begin : g_mid
      assign din = 1'b0;
    end
    sdmn_rem_stage #(.W(W)) u_rem (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (rem_ctl[j]),
      .din_bit_i(din),
      .ad_i     (rem_ad[j]),
      .rem_i    (rem_r[j]),
      .ctl_o    (rem_ctl[j+1]),
      .ad_o     (rem_ad[j+1]),
      .rem_o    (rem_r[j+1])
    );
  end

  // bias stage: anc = t - 1 - (t mod |d|), forced to 1 when that is zero
  logic [W-1:0] tm1, anc_raw, anc_d;

  assign tm1     = {1'b0, {(W-1){1'b1}}} + W'(rem_ctl[W].neg);
  assign anc_raw = tm1 - rem_r[W];
  assign anc_d   = (anc_raw == '0) ? W'(1) : anc_raw;

  sdmn_ctl_t     dv_ctl [0:NL];
  logic [W-1:0]  dv_ad  [0:NL];
  logic [W-1:0]  dv_anc [0:NL];
  logic [W-1:0]  dv_q1  [0:NL];
  logic [W-1:0]  dv_r1  [0:NL];
  logic [W-1:0]  dv_q2  [0:NL];
  logic [W-1:0]  dv_r2  [0:NL];
  logic [CW-1:0] dv_cnt [0:NL];

  sdmn_ctl_t    anc_ctl_q;
  logic [W-1:0] anc_ad_q, anc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anc_ctl_q <= '0;
    end else begin
      anc_ctl_q <= rem_ctl[W];
    end
  end

  always_ff @(posedge clk_i) begin
    anc_ad_q <= rem_ad[W];
    anc_q    <= anc_d;
  end

  assign dv_ctl[0] = anc_ctl_q;
  assign dv_ad[0]  = anc_ad_q;
  assign dv_anc[0] = anc_q;
  assign dv_q1[0]  = '0;
  assign dv_r1[0]  = '0;
  assign dv_q2[0]  = '0;
  assign dv_r2[0]  = '0;
  assign dv_cnt[0] = '0;

  // first W steps divide 2^(W-1), the rest continue with zero bits and test
  for (genvar j = 0; j < NL; j++) begin : g_div
    sdmn_div_stage #(.W(W), .CW(CW)) u_div (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (dv_ctl[j]),
      .din_bit_i(j == 0),
      .test_i   (j >= W),
      .ad_i     (dv_ad[j]),
      .anc_i    (dv_anc[j]),
      .q1_i     (dv_q1[j]),
      .r1_i     (dv_r1[j]),
      .q2_i     (dv_q2[j]),
      .r2_i     (dv_r2[j]),
      .cnt_i    (dv_cnt[j]),
      .ctl_o    (dv_ctl[j+1]),
      .ad_o     (dv_ad[j+1]),
      .anc_o    (dv_anc[j+1]),
      .q1_o     (dv_q1[j+1]),
      .r1_o     (dv_r1[j+1]),
      .q2_o     (dv_q2[j+1]),
      .r2_o     (dv_r2[j+1]),
      .cnt_o    (dv_cnt[j+1])
    );
  end

  // output stage
  logic [W-1:0]  mag_pos, mag;
  logic [CW-1:0] cnt_m1;
  logic          valid_q, inv_q;
  logic [RESULT_BITS-1:0] magic_q;
  logic [SHIFT_BITS-1:0]  shift_q;

  assign mag_pos = dv_q2[NL] + W'(1);
  assign mag     = dv_ctl[NL].neg ? (~mag_pos + W'(1)) : mag_pos;
  assign cnt_m1  = dv_cnt[NL] - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_ctl[NL].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    inv_q <= dv_ctl[NL].inv;
    if (dv_ctl[NL].inv) begin
      magic_q <= '0;
      shift_q <= '0;
    end else begin
      magic_q <= RESULT_BITS'(mag);
      shift_q <= SHIFT_BITS'(cnt_m1);
    end
  end

  assign busy               = 1'b0;
  assign valid_o            = valid_q;
  assign magic_multiplier_o = magic_q;
  assign shift_amount_o     = shift_q;
  assign divisor_invalid_o  = inv_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (divisor_i == 32'sd0) |-> ##LAT (valid_o && divisor_invalid_o))
    else $error("zero divisor not flagged");

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && divisor_invalid_o |-> (magic_multiplier_o == '0) && (shift_amount_o == '0))
    else $error("invalid divisor with nonzero result");

endmodule

`default_nettype wire
